[hw/rtl/rcr_pkg.sv]
// shared widths, types and constants of the rectangle corner rotator
package rcr_pkg;

    // field widths
    localparam int COORD_W       = 16;
    localparam int SIZE_W        = COORD_W - 1;
    localparam int ANGLE_W       = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int OUT_W         = COORD_W + 2;

    // internal widths
    localparam int PHASE_W = 32;
    localparam int FRAC_W  = 15;
    localparam int CS_W    = FRAC_W + 1;
    localparam int XY_W    = CS_W + 2;
    localparam int DELTA_W = COORD_W + 2;
    localparam int PROD_W  = DELTA_W + CS_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int QUOT_W  = SUM_W - FRAC_W;

    // stream word layout
    localparam int IN_BITS    = 4 * COORD_W + 2 * SIZE_W + ANGLE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 8 * OUT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int OFF_RX  = 0;
    localparam int OFF_RY  = OFF_RX + COORD_W;
    localparam int OFF_RW  = OFF_RY + COORD_W;
    localparam int OFF_RH  = OFF_RW + SIZE_W;
    localparam int OFF_PX  = OFF_RH + SIZE_W;
    localparam int OFF_PY  = OFF_PX + COORD_W;
    localparam int OFF_ANG = OFF_PY + COORD_W;

    // gain-compensated unit vector in q1.15
    localparam logic signed [XY_W-1:0] CORDIC_INIT = XY_W'(19898);

    // quarter turn in phase units
    localparam logic signed [PHASE_W-1:0] QUARTER     = 32'sh4000_0000;
    localparam logic signed [PHASE_W-1:0] NEG_QUARTER = 32'shC000_0000;

    localparam logic signed [CS_W-1:0] CS_MAX = {1'b0, {(CS_W-1){1'b1}}};
    localparam logic signed [CS_W-1:0] CS_MIN = {1'b1, {(CS_W-1){1'b0}}};

    localparam logic signed [QUOT_W-1:0] OUT_MAX = QUOT_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [QUOT_W-1:0] OUT_MIN = -OUT_MAX - QUOT_W'(1);

    // arctangent of 2^-i in phase units (2^32 per turn)
    localparam logic [PHASE_W-1:0] ATAN_TAB [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef logic signed [CS_W-1:0]    t_cs;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [COORD_W-1:0] t_coord;

    // geometry carried beside the sine/cosine pipeline
    typedef struct packed {
        t_delta dx_l;
        t_delta dx_r;
        t_delta dy_t;
        t_delta dy_b;
        t_coord px;
        t_coord py;
        logic   flip;
    } t_side;

endpackage

[hw/rtl/rcr_cordic.sv]
// pipelined rotation-mode cordic giving cos and sin in q1.15
module rcr_cordic
    import rcr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [PHASE_W-1:0] i_z,
    input  t_side                     i_side,
    output logic                      o_valid,
    output t_cs                       o_cos,
    output t_cs                       o_sin,
    output t_side                     o_side
);

    logic                      r_v    [1:CORDIC_STAGES];
    logic signed [XY_W-1:0]    r_x    [1:CORDIC_STAGES];
    logic signed [XY_W-1:0]    r_y    [1:CORDIC_STAGES];
    logic signed [PHASE_W-1:0] r_z    [1:CORDIC_STAGES];
    t_side                     r_side [1:CORDIC_STAGES];

    logic signed [XY_W-1:0] n_xf;
    logic signed [XY_W-1:0] n_yf;

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_stage
            logic                      w_v;
            logic signed [XY_W-1:0]    w_x;
            logic signed [XY_W-1:0]    w_y;
            logic signed [PHASE_W-1:0] w_z;
            t_side                     w_side;
            logic signed [PHASE_W-1:0] w_atan;

            // stage input: pipeline entry or previous stage
            if (gi == 0) begin : g_first
                assign w_v    = i_valid;
                assign w_x    = CORDIC_INIT;
                assign w_y    = '0;
                assign w_z    = i_z;
                assign w_side = i_side;
            end else begin : g_next
                assign w_v    = r_v[gi];
                assign w_x    = r_x[gi];
                assign w_y    = r_y[gi];
                assign w_z    = r_z[gi];
                assign w_side = r_side[gi];
            end

            assign w_atan = $signed(ATAN_TAB[gi]);

            // valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gi+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[gi+1] <= w_v;
                end
            end

            // one micro-rotation, direction from the sign of the residual angle
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!w_z[PHASE_W-1]) begin
                        r_x[gi+1] <= w_x - (w_y >>> gi);
                        r_y[gi+1] <= w_y + (w_x >>> gi);
                        r_z[gi+1] <= w_z - w_atan;
                    end else begin
                        r_x[gi+1] <= w_x + (w_y >>> gi);
                        r_y[gi+1] <= w_y - (w_x >>> gi);
                        r_z[gi+1] <= w_z + w_atan;
                    end
                    r_side[gi+1] <= w_side;
                end
            end
        end
    endgenerate

    // undo the half-turn fold
    always_comb begin
        if (r_side[CORDIC_STAGES].flip) begin
            n_xf = -r_x[CORDIC_STAGES];
            n_yf = -r_y[CORDIC_STAGES];
        end else begin
            n_xf = r_x[CORDIC_STAGES];
            n_yf = r_y[CORDIC_STAGES];
        end
    end

    // saturate to q1.15 and register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_xf > XY_W'(CS_MAX)) begin
                o_cos <= CS_MAX;
            end else if (n_xf < XY_W'(CS_MIN)) begin
                o_cos <= CS_MIN;
            end else begin
                o_cos <= CS_W'(n_xf);
            end
            if (n_yf > XY_W'(CS_MAX)) begin
                o_sin <= CS_MAX;
            end else if (n_yf < XY_W'(CS_MIN)) begin
                o_sin <= CS_MIN;
            end else begin
                o_sin <= CS_W'(n_yf);
            end
            o_side <= r_side[CORDIC_STAGES];
        end
    end

endmodule

[hw/rtl/rect_corner_rotator.sv]
// top level: rotates the four corners of a rectangle about a pivot point
//
// One rectangle word is taken per clock and its four rotated corners pass through one
// input register, 16 cordic micro-rotation stages, a sine/cosine saturation register,
// a multiply stage, a sum stage and the output register. The cordic stage count sets
// the latency. The whole pipeline advances together; while an output word waits for
// i_m_axis_tready the pipeline holds and the input is not ready, otherwise a word is
// taken on every clock. Results are truncated toward zero and saturated to 18-bit
// signed.
module rect_corner_rotator
    import rcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, pivot_x, pivot_y, angle_turns, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // top_left_x, top_left_y, top_right_x, top_right_y,
    // bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic w_adv;

    // input field views
    t_coord             w_rx;
    t_coord             w_ry;
    logic [SIZE_W-1:0]  w_rw;
    logic [SIZE_W-1:0]  w_rh;
    t_coord             w_px;
    t_coord             w_py;
    logic [ANGLE_W-1:0] w_ang;

    logic signed [PHASE_W-1:0] n_z;
    t_side                     n_side;

    logic                      r_s0_valid;
    logic signed [PHASE_W-1:0] r_s0_z;
    t_side                     r_s0_side;

    logic  w_cs_valid;
    t_cs   w_cos;
    t_cs   w_sin;
    t_side w_cs_side;

    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_lc, r_rc, r_ls, r_rs;
    logic signed [PROD_W-1:0] r_tc, r_bc, r_ts, r_bs;
    t_coord                   r_m_px;
    t_coord                   r_m_py;

    logic                    r_n_valid;
    logic signed [SUM_W-1:0] r_tl_x, r_tl_y, r_tr_x, r_tr_y;
    logic signed [SUM_W-1:0] r_bl_x, r_bl_y, r_br_x, r_br_y;

    logic signed [SUM_W-1:0] n_pxs;
    logic signed [SUM_W-1:0] n_pys;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    // pipeline advances whenever the output slot is free or being taken
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_rx  = i_s_axis_tdata[OFF_RX +: COORD_W];
    assign w_ry  = i_s_axis_tdata[OFF_RY +: COORD_W];
    assign w_rw  = i_s_axis_tdata[OFF_RW +: SIZE_W];
    assign w_rh  = i_s_axis_tdata[OFF_RH +: SIZE_W];
    assign w_px  = i_s_axis_tdata[OFF_PX +: COORD_W];
    assign w_py  = i_s_axis_tdata[OFF_PY +: COORD_W];
    assign w_ang = i_s_axis_tdata[OFF_ANG +: ANGLE_W];

    // phase word, folded into plus or minus a quarter turn
    always_comb begin
        n_z         = PHASE_W'(w_ang) << (PHASE_W - ANGLE_W);
        n_side.flip = (n_z > QUARTER) || (n_z < NEG_QUARTER);
        if (n_side.flip) begin
            n_z[PHASE_W-1] = ~n_z[PHASE_W-1];
        end
        n_side.dx_l = DELTA_W'(w_rx) - DELTA_W'(w_px);
        n_side.dx_r = DELTA_W'(w_rx) + $signed({{(DELTA_W-SIZE_W){1'b0}}, w_rw})
                      - DELTA_W'(w_px);
        n_side.dy_t = DELTA_W'(w_ry) - DELTA_W'(w_py);
        n_side.dy_b = DELTA_W'(w_ry) + $signed({{(DELTA_W-SIZE_W){1'b0}}, w_rh})
                      - DELTA_W'(w_py);
        n_side.px   = w_px;
        n_side.py   = w_py;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_z    <= n_z;
            r_s0_side <= n_side;
        end
    end

    rcr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s0_valid),
        .i_z     (r_s0_z),
        .i_side  (r_s0_side),
        .o_valid (w_cs_valid),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_side  (w_cs_side)
    );

    // multiply stage: offsets times cos and sin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= w_cs_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lc   <= w_cs_side.dx_l * w_cos;
            r_rc   <= w_cs_side.dx_r * w_cos;
            r_ls   <= w_cs_side.dx_l * w_sin;
            r_rs   <= w_cs_side.dx_r * w_sin;
            r_tc   <= w_cs_side.dy_t * w_cos;
            r_bc   <= w_cs_side.dy_b * w_cos;
            r_ts   <= w_cs_side.dy_t * w_sin;
            r_bs   <= w_cs_side.dy_b * w_sin;
            r_m_px <= w_cs_side.px;
            r_m_py <= w_cs_side.py;
        end
    end

    // sum stage: rotated offset plus pivot, still scaled by 2^15
    assign n_pxs = {{(SUM_W-COORD_W-FRAC_W){r_m_px[COORD_W-1]}}, r_m_px, {FRAC_W{1'b0}}};
    assign n_pys = {{(SUM_W-COORD_W-FRAC_W){r_m_py[COORD_W-1]}}, r_m_py, {FRAC_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (w_adv) begin
            r_n_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tl_x <= SUM_W'(r_lc) - SUM_W'(r_ts) + n_pxs;
            r_tl_y <= SUM_W'(r_ls) + SUM_W'(r_tc) + n_pys;
            r_tr_x <= SUM_W'(r_rc) - SUM_W'(r_ts) + n_pxs;
            r_tr_y <= SUM_W'(r_rs) + SUM_W'(r_tc) + n_pys;
            r_bl_x <= SUM_W'(r_lc) - SUM_W'(r_bs) + n_pxs;
            r_bl_y <= SUM_W'(r_ls) + SUM_W'(r_bc) + n_pys;
            r_br_x <= SUM_W'(r_rc) - SUM_W'(r_bs) + n_pxs;
            r_br_y <= SUM_W'(r_rs) + SUM_W'(r_bc) + n_pys;
        end
    end

    // scale back with truncation toward zero and saturate
    function automatic logic [OUT_W-1:0] f_finish(input logic signed [SUM_W-1:0] num);
        logic signed [QUOT_W-1:0] q;
        q = num[SUM_W-1:FRAC_W];
        if (num[SUM_W-1] && (num[FRAC_W-1:0] != '0)) begin
            q = q + QUOT_W'(1);
        end
        if (q > OUT_MAX) begin
            q = OUT_MAX;
        end else if (q < OUT_MIN) begin
            q = OUT_MIN;
        end
        return q[OUT_W-1:0];
    endfunction

    always_comb begin
        n_out_data                   = '0;
        n_out_data[0*OUT_W +: OUT_W] = f_finish(r_tl_x);
        n_out_data[1*OUT_W +: OUT_W] = f_finish(r_tl_y);
        n_out_data[2*OUT_W +: OUT_W] = f_finish(r_tr_x);
        n_out_data[3*OUT_W +: OUT_W] = f_finish(r_tr_y);
        n_out_data[4*OUT_W +: OUT_W] = f_finish(r_bl_x);
        n_out_data[5*OUT_W +: OUT_W] = f_finish(r_bl_y);
        n_out_data[6*OUT_W +: OUT_W] = f_finish(r_br_x);
        n_out_data[7*OUT_W +: OUT_W] = f_finish(r_br_y);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // no word comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid straight after reset");

    // cordic output stays close to the unit circle
    a_unit_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cs_valid |->
            ((32'(w_cos) * 32'(w_cos) + 32'(w_sin) * 32'(w_sin)) > 32'sd1071644672) &&
            ((32'(w_cos) * 32'(w_cos) + 32'(w_sin) * 32'(w_sin)) < 32'sd1075838976))
        else $error("sine and cosine off the unit circle");

    // a held output word keeps the multiply stage frozen
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> ($stable(r_lc) && $stable(r_m_valid)))
        else $error("pipeline moved while the output word was held");

endmodule
